>>> hw/rtl/cmpq_pkg.sv
// ----------------------------------------------------------------------------
// cmpq_pkg
// types and constants shared by the message priority queue modules
// ----------------------------------------------------------------------------
package cmpq_pkg;

    localparam int unsigned ID_W   = 11;
    localparam int unsigned LEN_W  = 4;
    localparam int unsigned DATA_W = 64;
    localparam int unsigned OCC_W  = 5;
    localparam int unsigned IN_TDATA_W  = 80;
    localparam int unsigned OUT_TDATA_W = 88;
    localparam int unsigned OUT_TUSER_W = 2;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_POP    = 1'b1;

    typedef struct packed {
        logic [ID_W-1:0]   prio;
        logic [ID_W-1:0]   id;
        logic [LEN_W-1:0]  len;
        logic [DATA_W-1:0] data;
    } t_ent;

    typedef struct packed {
        logic            le;
        logic [ID_W-1:0] dec;
    } t_alu_res;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS_RD,
        ST_INS_CMP,
        ST_INS_PUT,
        ST_POP_RD,
        ST_POP_WR,
        ST_HEAD,
        ST_DONE
    } t_state;

endpackage

>>> hw/rtl/can_message_priority_queue_aging.sv
// ----------------------------------------------------------------------------
// can_message_priority_queue_aging
// sorted message queue with priority aging, walked one entry at a time
// ----------------------------------------------------------------------------
// input stream: tuser is the command (0 insert, 1 pop), tdata the message.
// every input transfer yields exactly one output transfer reporting the head
// after the operation, the drop flag and the occupancy.
// an insert walks from the tail towards the head through the entry memory,
// shifting larger priorities up by one. a pop walks from the head to the
// tail, moving each entry down and decrementing its priority in the shared
// unit. every entry moved takes one read and one write through the memory
// ports (one read, one write). an insert into a full queue or a pop on an
// empty queue skips the walk. the result becomes valid in the same cycle
// as the next transfer can be accepted.
// s_tready is high only while no operation is in progress.
// the result sits in an output register; a further transfer is accepted
// while it waits, and the next result waits in the sequencer until taken.
// reset empties the queue and discards any pending result.
// ----------------------------------------------------------------------------
module can_message_priority_queue_aging #(
    parameter int unsigned DEPTH = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // msg_id, msg_length, msg_data, zero pad
    input  logic [cmpq_pkg::IN_TDATA_W-1:0]     i_s_tdata,
    // command
    input  logic                                i_s_tuser,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // head_id, head_length, head_data, occupancy, zero pad
    output logic [cmpq_pkg::OUT_TDATA_W-1:0]    o_m_tdata,
    // head_valid, insert_dropped
    output logic [cmpq_pkg::OUT_TUSER_W-1:0]    o_m_tuser
);
    import cmpq_pkg::*;

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_state r_state, n_state;
    logic [ID_W-1:0] r_key, n_key;
    logic [LEN_W-1:0] r_len, n_len;
    logic [DATA_W-1:0] r_data, n_data;
    logic [AW-1:0]   r_idx, n_idx;
    logic [CW-1:0]   r_count, n_count;
    logic            r_drop, n_drop;

    logic                    r_m_tvalid, n_m_tvalid;
    logic [OUT_TDATA_W-1:0]  r_m_tdata, n_m_tdata;
    logic [OUT_TUSER_W-1:0]  r_m_tuser, n_m_tuser;

    logic          w_we, w_re;
    logic [AW-1:0] w_waddr, w_raddr;
    t_ent          w_wdata, w_rdata, w_new;
    t_alu_res      w_alu;
    logic          w_out_free;
    logic          w_head_valid;

    cmpq_mem #(.DEPTH(DEPTH)) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    cmpq_alu u_alu (
        .i_prio (w_rdata.prio),
        .i_key  (r_key),
        .o_res  (w_alu)
    );

    assign w_new        = '{prio: r_key, id: r_key, len: r_len, data: r_data};
    assign w_out_free   = !r_m_tvalid || i_m_tready;
    assign w_head_valid = (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_count    <= '0;
            r_m_tvalid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_m_tvalid <= n_m_tvalid;
        end
        r_key     <= n_key;
        r_len     <= n_len;
        r_data    <= n_data;
        r_idx     <= n_idx;
        r_drop    <= n_drop;
        r_m_tdata <= n_m_tdata;
        r_m_tuser <= n_m_tuser;
    end

    always_comb begin
        n_state    = r_state;
        n_key      = r_key;
        n_len      = r_len;
        n_data     = r_data;
        n_idx      = r_idx;
        n_count    = r_count;
        n_drop     = r_drop;
        n_m_tvalid = r_m_tvalid && !i_m_tready;
        n_m_tdata  = r_m_tdata;
        n_m_tuser  = r_m_tuser;
        o_s_tready = 1'b0;
        w_we       = 1'b0;
        w_waddr    = r_idx;
        w_wdata    = w_rdata;
        w_re       = 1'b0;
        w_raddr    = r_idx;

        unique case (r_state)
            ST_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    n_key  = i_s_tdata[10:0];
                    n_len  = i_s_tdata[14:11];
                    n_data = i_s_tdata[78:15];
                    n_drop = 1'b0;
                    n_state = ST_HEAD;
                    if (i_s_tuser == CMD_INSERT) begin
                        if (r_count == CW'(DEPTH)) begin
                            n_drop = 1'b1;
                        end else if (r_count == '0) begin
                            n_idx   = '0;
                            n_state = ST_INS_PUT;
                        end else begin
                            n_idx   = AW'(r_count - CW'(1));
                            n_state = ST_INS_RD;
                        end
                    end else begin
                        if (r_count == CW'(1)) begin
                            n_count = '0;
                        end else if (r_count != '0) begin
                            n_idx   = AW'(1);
                            n_state = ST_POP_RD;
                        end
                    end
                end
            end
            ST_INS_RD: begin
                w_re    = 1'b1;
                n_state = ST_INS_CMP;
            end
            ST_INS_CMP: begin
                if (w_alu.le) begin
                    n_idx   = r_idx + AW'(1);
                    n_state = ST_INS_PUT;
                end else begin
                    w_we    = 1'b1;
                    w_waddr = r_idx + AW'(1);
                    if (r_idx == '0) begin
                        n_state = ST_INS_PUT;
                    end else begin
                        n_idx   = r_idx - AW'(1);
                        n_state = ST_INS_RD;
                    end
                end
            end
            ST_INS_PUT: begin
                w_we    = 1'b1;
                w_wdata = w_new;
                n_count = r_count + CW'(1);
                n_state = ST_HEAD;
            end
            ST_POP_RD: begin
                w_re    = 1'b1;
                n_state = ST_POP_WR;
            end
            ST_POP_WR: begin
                w_we         = 1'b1;
                w_waddr      = r_idx - AW'(1);
                w_wdata.prio = w_alu.dec;
                if (CW'(r_idx) == r_count - CW'(1)) begin
                    n_count = r_count - CW'(1);
                    n_state = ST_HEAD;
                end else begin
                    n_idx   = r_idx + AW'(1);
                    n_state = ST_POP_RD;
                end
            end
            ST_HEAD: begin
                w_re    = 1'b1;
                w_raddr = '0;
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_m_tvalid = 1'b1;
                    if (w_head_valid) begin
                        n_m_tdata = {4'b0, OCC_W'(r_count), w_rdata.data,
                                     w_rdata.len, w_rdata.id};
                    end else begin
                        n_m_tdata = {4'b0, OCC_W'(r_count), 79'b0};
                    end
                    n_m_tuser = {r_drop, w_head_valid};
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = r_m_tdata;
    assign o_m_tuser  = r_m_tuser;

endmodule

>>> hw/rtl/cmpq_alu.sv
// ----------------------------------------------------------------------------
// cmpq_alu
// shared priority unit: compare against the search key and aged decrement
// ----------------------------------------------------------------------------
module cmpq_alu (
    input  logic [cmpq_pkg::ID_W-1:0] i_prio,
    input  logic [cmpq_pkg::ID_W-1:0] i_key,
    output cmpq_pkg::t_alu_res        o_res
);
    import cmpq_pkg::*;

    always_comb begin
        o_res.le  = (i_prio <= i_key);
        o_res.dec = (i_prio == '0) ? '0 : i_prio - ID_W'(1);
    end

endmodule

>>> hw/rtl/cmpq_mem.sv
// ----------------------------------------------------------------------------
// cmpq_mem
// entry storage, one write port and one registered read port
// ----------------------------------------------------------------------------
module cmpq_mem #(
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  cmpq_pkg::t_ent           i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output cmpq_pkg::t_ent           o_rdata
);
    import cmpq_pkg::*;

    t_ent r_mem [DEPTH];
    t_ent r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the aging message priority queue
// ----------------------------------------------------------------------------
// commands go in over the slave stream, and each head report that comes out is
// checked against a shadow copy of the sorted queue kept in the bench. there is
// a short directed part, then random streams under several idle and stall
// mixes, and a long output hold that fills the block and stalls its input.
// ----------------------------------------------------------------------------
module tb_top;
    import cmpq_pkg::*;

    localparam int unsigned QDEPTH         = 16;
    localparam int unsigned WATCHDOG_LIMIT = 5000;
    localparam int unsigned SETTLE_CYCLES  = 100;
    localparam int unsigned HOLD_CYCLES    = 400;

    typedef struct {
        logic              head_valid;
        logic [ID_W-1:0]   head_id;
        logic [LEN_W-1:0]  head_length;
        logic [DATA_W-1:0] head_data;
        logic              insert_dropped;
        logic [OCC_W-1:0]  occupancy;
    } t_head_report;

    logic                   i_clk      = 1'b0;
    logic                   i_rst_n    = 1'b0;
    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    logic [IN_TDATA_W-1:0]  i_s_tdata  = '0;
    logic                   i_s_tuser  = CMD_INSERT;
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_tdata;
    logic [OUT_TUSER_W-1:0] o_m_tuser;

    t_head_report      head_reports_due[$];
    logic [ID_W-1:0]   held_prio[QDEPTH];
    logic [ID_W-1:0]   held_id[QDEPTH];
    logic [LEN_W-1:0]  held_len[QDEPTH];
    logic [DATA_W-1:0] held_data[QDEPTH];
    int                held_n         = 0;
    int unsigned       errors         = 0;
    int unsigned       src_idle_pct   = 0;
    int unsigned       sink_stall_pct = 0;
    int unsigned       hold_left      = 0;
    int unsigned       quiet_cycles   = 0;

    can_message_priority_queue_aging #(
        .DEPTH(QDEPTH)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic t_head_report apply_to_queue(input logic cmd,
                                                    input logic [ID_W-1:0] id,
                                                    input logic [LEN_W-1:0] len,
                                                    input logic [DATA_W-1:0] data);
        t_head_report r;
        int pos;
        r.insert_dropped = 1'b0;
        if (cmd == CMD_INSERT) begin
            if (held_n >= QDEPTH) begin
                r.insert_dropped = 1'b1;
            end else begin
                pos = 0;
                while (pos < held_n && held_prio[pos] <= id)
                    pos++;
                for (int i = held_n; i > pos; i--) begin
                    held_prio[i] = held_prio[i-1];
                    held_id[i]   = held_id[i-1];
                    held_len[i]  = held_len[i-1];
                    held_data[i] = held_data[i-1];
                end
                held_prio[pos] = id;
                held_id[pos]   = id;
                held_len[pos]  = len;
                held_data[pos] = data;
                held_n++;
            end
        end else if (held_n > 0) begin
            // remove the head and age everything behind it, saturating at zero
            for (int i = 0; i + 1 < held_n; i++) begin
                held_prio[i] = (held_prio[i+1] != '0) ? held_prio[i+1] - 1'b1 : '0;
                held_id[i]   = held_id[i+1];
                held_len[i]  = held_len[i+1];
                held_data[i] = held_data[i+1];
            end
            held_n--;
        end
        r.head_valid  = (held_n > 0);
        r.head_id     = r.head_valid ? held_id[0]   : '0;
        r.head_length = r.head_valid ? held_len[0]  : '0;
        r.head_data   = r.head_valid ? held_data[0] : '0;
        r.occupancy   = OCC_W'(held_n);
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [DATA_W-1:0] want,
                                        input logic [DATA_W-1:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            errors++;
        end
    endfunction

    function automatic logic [ID_W-1:0] pick_id();
        case ($urandom_range(9))
            0, 1, 2, 3: return ID_W'($urandom_range(7));
            4, 5:       return ID_W'($urandom_range(2047, 2040));
            default:    return ID_W'($urandom_range(2047));
        endcase
    endfunction

    task automatic send_cmd(input logic cmd, input logic [ID_W-1:0] id,
                            input logic [LEN_W-1:0] len, input logic [DATA_W-1:0] data);
        @(negedge i_clk);
        while ($urandom_range(99) < src_idle_pct) begin
            i_s_tvalid = 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid = 1'b1;
        i_s_tuser  = cmd;
        i_s_tdata  = {1'b0, data, len, id};
        do
            @(posedge i_clk);
        while (!o_s_tready);
        head_reports_due.push_back(apply_to_queue(cmd, id, len, data));
    endtask

    task automatic send_random(input int unsigned insert_pct);
        logic cmd;
        cmd = ($urandom_range(99) < insert_pct) ? CMD_INSERT : CMD_POP;
        send_cmd(cmd, pick_id(), LEN_W'($urandom_range(8)), {$urandom, $urandom});
    endtask

    // sink side, with the long hold counted down here
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_m_tready = 1'b0;
            hold_left--;
        end else begin
            i_m_tready = ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge i_clk) begin : report_check
        t_head_report due;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (head_reports_due.size() == 0) begin
                $error("head report transfer with none outstanding");
                errors++;
            end else begin
                due = head_reports_due.pop_front();
                check_field("head_valid", due.head_valid, o_m_tuser[0]);
                check_field("insert_dropped", due.insert_dropped, o_m_tuser[1]);
                check_field("head_id", due.head_id, o_m_tdata[ID_W-1:0]);
                check_field("head_length", due.head_length, o_m_tdata[ID_W+LEN_W-1:ID_W]);
                check_field("head_data", due.head_data,
                            o_m_tdata[ID_W+LEN_W+DATA_W-1:ID_W+LEN_W]);
                check_field("occupancy", due.occupancy,
                            o_m_tdata[ID_W+LEN_W+DATA_W+OCC_W-1:ID_W+LEN_W+DATA_W]);
            end
        end
    end

    initial begin : watchdog
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("** can_message_priority_queue_aging: FAILED **");
        $finish;
    end

    task automatic test_reset();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
    endtask

    task automatic test_directed_extremes();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        send_cmd(CMD_POP, 11'd0, 4'd0, '0);
        send_cmd(CMD_INSERT, 11'd2047, 4'd8, '1);
        send_cmd(CMD_INSERT, 11'd0, 4'd0, '0);
        send_cmd(CMD_INSERT, 11'd0, 4'd7, 64'h5555_5555_5555_5555);
        send_cmd(CMD_INSERT, 11'd1, 4'd1, 64'haaaa_aaaa_aaaa_aaaa);
        // aged entries now tie with a fresh id 0, which must queue behind them
        send_cmd(CMD_POP, 11'd2047, 4'd8, '1);
        send_cmd(CMD_INSERT, 11'd0, 4'd2, 64'h0123_4567_89ab_cdef);
        repeat (5)
            send_cmd(CMD_POP, 11'd0, 4'd0, '0);
    endtask

    task automatic test_full_queue();
        for (int i = 0; i < QDEPTH; i++)
            send_cmd(CMD_INSERT, ID_W'(2047 - 100 * i), LEN_W'($urandom_range(8)),
                     {$urandom, $urandom});
        send_cmd(CMD_INSERT, 11'd0, 4'd8, {$urandom, $urandom});
    endtask

    task automatic test_random_stream(input int unsigned count, input int unsigned src_pct,
                                      input int unsigned sink_pct);
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        // alternate filling and draining stretches so both ends are reached
        for (int unsigned n = 0; n < count; n++)
            send_random(((n / 40) % 2 == 0) ? 70 : 35);
    endtask

    task automatic test_output_hold();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        hold_left      = HOLD_CYCLES;
        repeat (20)
            send_random(60);
    endtask

    initial begin
        test_reset();
        test_directed_extremes();
        test_full_queue();
        test_random_stream(280, 0, 0);
        test_random_stream(280, 88, 0);
        test_random_stream(280, 0, 88);
        test_random_stream(280, 27, 27);
        test_output_hold();
        test_random_stream(20, 0, 0);
        @(negedge i_clk);
        i_s_tvalid = 1'b0;
        while (head_reports_due.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (errors == 0)
            $display("** can_message_priority_queue_aging: PASSED **");
        else
            $display("** can_message_priority_queue_aging: FAILED **");
        $finish;
    end

endmodule
